// ===== hw/rtl/gvlc_pkg.sv =====
// Shared types, constants and saturating helpers for the G-code volume limit checker.
// Depends on nothing; the top level and the front, queue and back parts import it.
`timescale 1ns / 1ps
`default_nettype none

package gvlc_pkg;

    // Width of the tracked coordinates and the XY tolerance around the printable area
    localparam int COORD_W      = 32;
    localparam int XY_MARGIN_UM = 5000;

    // Width that holds any sum of a coordinate and a 32-bit input word
    localparam int SUM_W = ((COORD_W > 32) ? COORD_W : 32) + 1;
    // Width for comparing a coordinate against a widened 32-bit bound
    localparam int LIM_W = ((COORD_W > 33) ? COORD_W : 33) + 1;

    localparam logic signed [SUM_W-1:0] CMAX_S =
        {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] CMIN_S = ~CMAX_S;

    // Decoded line kinds
    typedef enum logic [2:0] {
        REQ_ABS_XYZ = 3'd0,
        REQ_REL_XYZ = 3'd1,
        REQ_ABS_E   = 3'd2,
        REQ_REL_E   = 3'd3,
        REQ_SET_POS = 3'd4,
        REQ_MOVE    = 3'd5,
        REQ_OTHER   = 3'd6
    } req_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_BOUNDS_VALID = 3'd0,
        CFG_MIN_X        = 3'd1,
        CFG_MAX_X        = 3'd2,
        CFG_MIN_Y        = 3'd3,
        CFG_MAX_Y        = 3'd4,
        CFG_MAX_Z        = 3'd5
    } cfg_idx_t;

    // One classified line handed from the front to the back
    typedef struct packed {
        logic                      check;
        logic [31:0]               line;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
    } gvlc_cmd_t;

    // Checking limits, with the XY margin already applied
    typedef struct packed {
        logic                    valid;
        logic signed [LIM_W-1:0] min_x;
        logic signed [LIM_W-1:0] max_x;
        logic signed [LIM_W-1:0] min_y;
        logic signed [LIM_W-1:0] max_y;
        logic signed [LIM_W-1:0] max_z;
    } gvlc_bounds_t;

    // Clamp a wide value into the coordinate range
    function automatic logic signed [COORD_W-1:0] clamp_c(input logic signed [SUM_W-1:0] v);
        if (v > CMAX_S) begin
            return CMAX_S[COORD_W-1:0];
        end
        if (v < CMIN_S) begin
            return CMIN_S[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

    // Clamp a 32-bit input word into the coordinate range
    function automatic logic signed [COORD_W-1:0] clamp_in(input logic signed [31:0] v);
        return clamp_c(SUM_W'(v));
    endfunction

    // Saturating add of a 32-bit word to a coordinate
    function automatic logic signed [COORD_W-1:0] sat_add(
        input logic signed [COORD_W-1:0] cur,
        input logic signed [31:0]        v
    );
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(cur) + SUM_W'(v);
        return clamp_c(s);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gcode_volume_limit_checker.sv =====
// Top level of the G-code volume limit checker: configuration registers and part wiring.
// Depends on gvlc_pkg, gvlc_front, gvlc_queue and gvlc_back.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one decoded G-code line per cycle while in_stall is low and returns
// one report per line: the extruded bounding box, sticky area and height flags and the
// first offending line. Each line is queued and its report is registered; the front
// part (position tracking, saturating adds) and the back part (box and limit compares)
// each finish a line per cycle unless stalled, and a two-entry queue between them
// absorbs an output stall so input keeps flowing until the queue fills. Configuration
// writes are always ready and take effect at once; write them only while no line is in
// flight. Register 0 enables checking; while it is 0 every report is zero.
module gcode_volume_limit_checker
    import gvlc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         req_type,
    input  wire logic               has_x,
    input  wire logic signed [31:0] x_value,
    input  wire logic               has_y,
    input  wire logic signed [31:0] y_value,
    input  wire logic               has_z,
    input  wire logic signed [31:0] z_value,
    input  wire logic               has_e,
    input  wire logic signed [31:0] e_value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    extrusion_seen,
    output logic signed [31:0]      extent_min_x,
    output logic signed [31:0]      extent_max_x,
    output logic signed [31:0]      extent_min_y,
    output logic signed [31:0]      extent_max_y,
    output logic signed [31:0]      extent_max_z,
    output logic                    area_exceeded,
    output logic                    height_exceeded,
    output logic [31:0]             first_bad_line
);

    logic               valid_reg;
    logic signed [31:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg, max_z_reg;
    gvlc_bounds_t       bounds;
    gvlc_cmd_t          cmd;
    gvlc_cmd_t          head;
    logic               push, pop, q_full, head_valid;

    assign cfg_ready = 1'b1;

    // Write configuration registers on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            min_x_reg <= '0;
            max_x_reg <= '0;
            min_y_reg <= '0;
            max_y_reg <= '0;
            max_z_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BOUNDS_VALID: valid_reg <= cfg_data[0];
                CFG_MIN_X:        min_x_reg <= cfg_data;
                CFG_MAX_X:        max_x_reg <= cfg_data;
                CFG_MIN_Y:        min_y_reg <= cfg_data;
                CFG_MAX_Y:        max_y_reg <= cfg_data;
                CFG_MAX_Z:        max_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Widen the XY area by the margin
    always_comb
    begin
        bounds.valid = valid_reg;
        bounds.min_x = LIM_W'(min_x_reg) - LIM_W'(XY_MARGIN_UM);
        bounds.max_x = LIM_W'(max_x_reg) + LIM_W'(XY_MARGIN_UM);
        bounds.min_y = LIM_W'(min_y_reg) - LIM_W'(XY_MARGIN_UM);
        bounds.max_y = LIM_W'(max_y_reg) + LIM_W'(XY_MARGIN_UM);
        bounds.max_z = LIM_W'(max_z_reg);
    end

    gvlc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .has_x    (has_x),
        .x_value  (x_value),
        .has_y    (has_y),
        .y_value  (y_value),
        .has_z    (has_z),
        .z_value  (z_value),
        .has_e    (has_e),
        .e_value  (e_value),
        .q_full   (q_full),
        .push     (push),
        .cmd      (cmd)
    );

    gvlc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (cmd),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    gvlc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head            (head),
        .pop             (pop),
        .bounds          (bounds),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .extrusion_seen  (extrusion_seen),
        .extent_min_x    (extent_min_x),
        .extent_max_x    (extent_max_x),
        .extent_min_y    (extent_min_y),
        .extent_max_y    (extent_max_y),
        .extent_max_z    (extent_max_z),
        .area_exceeded   (area_exceeded),
        .height_exceeded (height_exceeded),
        .first_bad_line  (first_bad_line)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/gvlc_front.sv =====
// Front part: accepts decoded lines, tracks position, modes and line count, classifies moves.
// Depends on gvlc_pkg; feeds gvlc_queue.
`timescale 1ns / 1ps
`default_nettype none

module gvlc_front
    import gvlc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         req_type,
    input  wire logic               has_x,
    input  wire logic signed [31:0] x_value,
    input  wire logic               has_y,
    input  wire logic signed [31:0] y_value,
    input  wire logic               has_z,
    input  wire logic signed [31:0] z_value,
    input  wire logic               has_e,
    input  wire logic signed [31:0] e_value,
    input  wire logic               q_full,
    output logic                    push,
    output gvlc_cmd_t               cmd
);

    logic signed [COORD_W-1:0] pos_x_reg, pos_x_next;
    logic signed [COORD_W-1:0] pos_y_reg, pos_y_next;
    logic signed [COORD_W-1:0] pos_z_reg, pos_z_next;
    logic signed [COORD_W-1:0] pos_e_reg, pos_e_next;
    logic                      xyz_rel_reg, xyz_rel_next;
    logic                      e_rel_reg, e_rel_next;
    logic                      e_known_reg, e_known_next;
    logic [31:0]               line_reg, line_next;
    logic signed [COORD_W-1:0] e_abs;
    logic                      extruding;
    logic                      spatial;
    logic                      accept;

    // Hold input while the queue has no room
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign push     = accept;

    assign e_abs   = clamp_in(e_value);
    assign spatial = has_x || has_y || has_z;

    // Work out the state after this line
    always_comb
    begin
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        pos_z_next   = pos_z_reg;
        pos_e_next   = pos_e_reg;
        xyz_rel_next = xyz_rel_reg;
        e_rel_next   = e_rel_reg;
        e_known_next = e_known_reg;
        extruding    = 1'b0;
        line_next    = (line_reg == 32'hFFFF_FFFF) ? line_reg : line_reg + 32'd1;
        unique case (req_type)
            REQ_ABS_XYZ: xyz_rel_next = 1'b0;
            REQ_REL_XYZ: xyz_rel_next = 1'b1;
            REQ_ABS_E:   e_rel_next   = 1'b0;
            REQ_REL_E:   e_rel_next   = 1'b1;
            REQ_SET_POS:
            begin
                if (has_e)
                begin
                    pos_e_next   = e_abs;
                    e_known_next = 1'b1;
                end
            end
            REQ_MOVE:
            begin
                if (has_e)
                begin
                    if (e_rel_reg)
                    begin
                        extruding  = (e_value > 32'sd0);
                        pos_e_next = sat_add(pos_e_reg, e_value);
                    end
                    else
                    begin
                        extruding  = !e_known_reg || (e_abs > pos_e_reg);
                        pos_e_next = e_abs;
                    end
                    e_known_next = 1'b1;
                end
                if (has_x)
                begin
                    pos_x_next = xyz_rel_reg ? sat_add(pos_x_reg, x_value) : clamp_in(x_value);
                end
                if (has_y)
                begin
                    pos_y_next = xyz_rel_reg ? sat_add(pos_y_reg, y_value) : clamp_in(y_value);
                end
                if (has_z)
                begin
                    pos_z_next = xyz_rel_reg ? sat_add(pos_z_reg, z_value) : clamp_in(z_value);
                end
            end
            default: ;
        endcase
    end

    // Classified line for the back part
    always_comb
    begin
        cmd.check = extruding && spatial;
        cmd.line  = line_next;
        cmd.px    = pos_x_next;
        cmd.py    = pos_y_next;
        cmd.pz    = pos_z_next;
    end

    // Advance tracked state on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            pos_z_reg   <= '0;
            pos_e_reg   <= '0;
            xyz_rel_reg <= 1'b0;
            e_rel_reg   <= 1'b0;
            e_known_reg <= 1'b0;
            line_reg    <= '0;
        end
        else if (accept)
        begin
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            pos_z_reg   <= pos_z_next;
            pos_e_reg   <= pos_e_next;
            xyz_rel_reg <= xyz_rel_next;
            e_rel_reg   <= e_rel_next;
            e_known_reg <= e_known_next;
            line_reg    <= line_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gvlc_queue.sv =====
// Two-entry queue of classified lines between the front and back parts.
// Depends on gvlc_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module gvlc_queue
    import gvlc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire gvlc_cmd_t push_data,
    input  wire logic      pop,
    output logic           full,
    output logic           head_valid,
    output gvlc_cmd_t      head
);

    gvlc_cmd_t   slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gvlc_back.sv =====
// Back part: updates the bounding box, violation flags and first bad line; drives the report.
// Depends on gvlc_pkg; reads entries from gvlc_queue.
`timescale 1ns / 1ps
`default_nettype none

module gvlc_back
    import gvlc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               head_valid,
    input  wire gvlc_cmd_t          head,
    output logic                    pop,
    input  wire gvlc_bounds_t       bounds,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    extrusion_seen,
    output logic signed [31:0]      extent_min_x,
    output logic signed [31:0]      extent_max_x,
    output logic signed [31:0]      extent_min_y,
    output logic signed [31:0]      extent_max_y,
    output logic signed [31:0]      extent_max_z,
    output logic                    area_exceeded,
    output logic                    height_exceeded,
    output logic [31:0]             first_bad_line
);

    logic                      seen_reg, seen_next;
    logic signed [COORD_W-1:0] min_x_reg, min_x_next;
    logic signed [COORD_W-1:0] max_x_reg, max_x_next;
    logic signed [COORD_W-1:0] min_y_reg, min_y_next;
    logic signed [COORD_W-1:0] max_y_reg, max_y_next;
    logic signed [COORD_W-1:0] max_z_reg, max_z_next;
    logic                      area_reg, area_next;
    logic                      height_reg, height_next;
    logic [31:0]               bad_reg, bad_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      o_seen_reg;
    logic signed [31:0]        o_min_x_reg, o_max_x_reg, o_min_y_reg, o_max_y_reg, o_max_z_reg;
    logic                      o_area_reg, o_height_reg;
    logic [31:0]               o_bad_reg;
    logic                      oxy, oz;

    // Take the next entry once the output register is free or being drained
    assign pop = head_valid && (!out_valid_reg || !out_stall);

    // Check the position against the widened area and the height limit
    assign oxy = (LIM_W'(head.px) < bounds.min_x) || (LIM_W'(head.px) > bounds.max_x) ||
                 (LIM_W'(head.py) < bounds.min_y) || (LIM_W'(head.py) > bounds.max_y);
    assign oz  = (LIM_W'(head.pz) > bounds.max_z);

    // Update the report state for a checked move
    always_comb
    begin
        seen_next   = seen_reg;
        min_x_next  = min_x_reg;
        max_x_next  = max_x_reg;
        min_y_next  = min_y_reg;
        max_y_next  = max_y_reg;
        max_z_next  = max_z_reg;
        area_next   = area_reg;
        height_next = height_reg;
        bad_next    = bad_reg;
        if (head.check && bounds.valid)
        begin
            seen_next = 1'b1;
            if (!seen_reg)
            begin
                min_x_next = head.px;
                max_x_next = head.px;
                min_y_next = head.py;
                max_y_next = head.py;
                max_z_next = head.pz;
            end
            else
            begin
                if (head.px < min_x_reg) min_x_next = head.px;
                if (head.px > max_x_reg) max_x_next = head.px;
                if (head.py < min_y_reg) min_y_next = head.py;
                if (head.py > max_y_reg) max_y_next = head.py;
                if (head.pz > max_z_reg) max_z_next = head.pz;
            end
            if (oxy || oz)
            begin
                area_next   = area_reg || oxy;
                height_next = height_reg || oz;
                if (bad_reg == 32'd0)
                begin
                    bad_next = head.line;
                end
            end
        end
    end

    // Hold a result until it is taken
    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            min_x_reg     <= '0;
            max_x_reg     <= '0;
            min_y_reg     <= '0;
            max_y_reg     <= '0;
            max_z_reg     <= '0;
            area_reg      <= 1'b0;
            height_reg    <= 1'b0;
            bad_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                seen_reg   <= seen_next;
                min_x_reg  <= min_x_next;
                max_x_reg  <= max_x_next;
                min_y_reg  <= min_y_next;
                max_y_reg  <= max_y_next;
                max_z_reg  <= max_z_next;
                area_reg   <= area_next;
                height_reg <= height_next;
                bad_reg    <= bad_next;
            end
        end
    end

    // Load the report; drop it to zero while checking is off
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (bounds.valid)
            begin
                o_seen_reg   <= seen_next;
                o_min_x_reg  <= 32'(min_x_next);
                o_max_x_reg  <= 32'(max_x_next);
                o_min_y_reg  <= 32'(min_y_next);
                o_max_y_reg  <= 32'(max_y_next);
                o_max_z_reg  <= 32'(max_z_next);
                o_area_reg   <= area_next;
                o_height_reg <= height_next;
                o_bad_reg    <= bad_next;
            end
            else
            begin
                o_seen_reg   <= 1'b0;
                o_min_x_reg  <= '0;
                o_max_x_reg  <= '0;
                o_min_y_reg  <= '0;
                o_max_y_reg  <= '0;
                o_max_z_reg  <= '0;
                o_area_reg   <= 1'b0;
                o_height_reg <= 1'b0;
                o_bad_reg    <= '0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign extrusion_seen  = o_seen_reg;
    assign extent_min_x    = o_min_x_reg;
    assign extent_max_x    = o_max_x_reg;
    assign extent_min_y    = o_min_y_reg;
    assign extent_max_y    = o_max_y_reg;
    assign extent_max_z    = o_max_z_reg;
    assign area_exceeded   = o_area_reg;
    assign height_exceeded = o_height_reg;
    assign first_bad_line  = o_bad_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/gvlc_checker.sv =====
// Port-level assertions for the G-code volume limit checker, bound to its top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module gvlc_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic               extrusion_seen,
    input  wire logic signed [31:0] extent_min_x,
    input  wire logic signed [31:0] extent_max_x,
    input  wire logic signed [31:0] extent_min_y,
    input  wire logic signed [31:0] extent_max_y,
    input  wire logic signed [31:0] extent_max_z,
    input  wire logic               area_exceeded,
    input  wire logic               height_exceeded,
    input  wire logic [31:0]        first_bad_line
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A bad line is recorded exactly when a violation flag is set
    a_bad_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((area_exceeded || height_exceeded) == (first_bad_line != 32'd0)))
        else $error("first bad line disagrees with violation flags");

    // Nothing is reported before the first extruding move
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !extrusion_seen |->
            extent_min_x == 32'sd0 && extent_max_x == 32'sd0 && extent_min_y == 32'sd0 &&
            extent_max_y == 32'sd0 && extent_max_z == 32'sd0 &&
            !area_exceeded && !height_exceeded)
        else $error("report not empty before any extrusion");

    // The box is ordered once it exists
    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && extrusion_seen |->
            extent_min_x <= extent_max_x && extent_min_y <= extent_max_y)
        else $error("bounding box inverted");

endmodule

bind gcode_volume_limit_checker gvlc_checker u_gvlc_checker (.*);

`default_nettype wire
